@@ rtl/ska_pkg.sv @@
`default_nettype none
package ska_pkg;

   localparam int KEY_W      = 64;
   localparam int CNT_W      = 32;
   localparam int ZOOM_W     = 6;
   localparam int ZOOM_FULL  = 32;
   localparam int SHAMT_W    = 7;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_END    = 1'b1;
   localparam logic KIND_GROUP = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   localparam logic REG_ZOOM      = 1'b0;
   localparam logic REG_COUNT_CAP = 1'b1;

   typedef struct packed {
      logic             cmd;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] count;
   } req_payload_type;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] group_key;
      logic [CNT_W-1:0] group_count;
   } rsp_payload_type;

   // Classified request as held in the queue between front and back.
   typedef struct packed {
      logic             is_end;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] count;
   } que_entry_type;

   typedef struct packed {
      logic [ZOOM_W-1:0] zoom;
      logic [CNT_W-1:0]  count_cap;
   } cfg_type;

   function automatic logic [KEY_W-1:0] key_mask(input logic [ZOOM_W-1:0] zoom);
      logic [SHAMT_W-1:0] shamt;
      logic [KEY_W-1:0]   mask;
      shamt = SHAMT_W'(KEY_W) - SHAMT_W'({zoom, 1'b0});
      if (zoom == '0) begin
         mask = '0;
      end else if (zoom >= ZOOM_W'(ZOOM_FULL)) begin
         mask = '1;
      end else begin
         mask = {KEY_W{1'b1}} << shamt;
      end
      return mask;
   endfunction

endpackage
`default_nettype wire

@@ rtl/ska_csr.sv @@
`default_nettype none
module ska_csr
   import ska_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic [ZOOM_W-1:0] zoom_ff, zoom_in;
   logic [CNT_W-1:0]  count_cap_ff, count_cap_in;
   logic              wr_en;
   logic              reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      zoom_in      = zoom_ff;
      count_cap_in = count_cap_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_ZOOM:      zoom_in      = pwdata[ZOOM_W-1:0];
            REG_COUNT_CAP: count_cap_in = pwdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_ZOOM:      prdata = DATA_W'(zoom_ff);
         REG_COUNT_CAP: prdata = DATA_W'(count_cap_ff);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff      <= '0;
         count_cap_ff <= '1;
      end else begin
         zoom_ff      <= zoom_in;
         count_cap_ff <= count_cap_in;
      end
   end

   assign cfg.zoom      = zoom_ff;
   assign cfg.count_cap = count_cap_ff;

endmodule
`default_nettype wire

@@ rtl/ska_front.sv @@
`default_nettype none
module ska_front
   import ska_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_payload_type   req_payload,
   input  wire logic [ZOOM_W-1:0] zoom,
   input  wire logic              q_full,
   output logic                   q_push,
   output que_entry_type          q_wdata
);

   logic          front_valid_ff, front_valid_in;
   que_entry_type front_data_ff, front_data_in;
   logic          take;

   // Load a new request whenever the held one is gone or moves on this cycle.
   assign take      = !front_valid_ff || !q_full;
   assign req_stall = !take;
   assign q_push    = front_valid_ff && !q_full;
   assign q_wdata   = front_data_ff;

   always_comb begin
      front_valid_in = take ? req_valid : front_valid_ff;
      front_data_in  = front_data_ff;
      if (take && req_valid) begin
         front_data_in.is_end = (req_payload.cmd == CMD_END);
         front_data_in.key    = req_payload.key & key_mask(zoom);
         front_data_in.count  = req_payload.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_data_ff <= front_data_in;
   end

endmodule
`default_nettype wire

@@ rtl/ska_fifo.sv @@
`default_nettype none
module ska_fifo
   import ska_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire que_entry_type wdata,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output que_entry_type      rdata
);

   que_entry_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rdata     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue occupancy beyond depth");

endmodule
`default_nettype wire

@@ rtl/ska_back.sv @@
`default_nettype none
module ska_back
   import ska_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             q_not_empty,
   input  wire que_entry_type    q_rdata,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_payload_type       rsp_payload
);

   logic [KEY_W-1:0] open_key_ff, open_key_in;
   logic [CNT_W-1:0] open_count_ff, open_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic [CNT_W:0]   sum;
   logic             is_low;
   logic             split;
   logic             emit;
   rsp_payload_type  result;

   // Advance when the result register is empty or being taken.
   assign q_pop = q_not_empty && (!rsp_valid_ff || !rsp_stall);

   assign sum    = {1'b0, open_count_ff} + {1'b0, q_rdata.count};
   assign is_low = q_rdata.key < open_key_ff;
   assign split  = (q_rdata.key != open_key_ff) || (sum > {1'b0, cfg.count_cap});

   always_comb begin
      open_key_in   = open_key_ff;
      open_count_in = open_count_ff;
      emit          = 1'b0;
      result.kind        = KIND_GROUP;
      result.group_key   = open_key_ff;
      result.group_count = open_count_ff;
      if (q_rdata.is_end) begin
         emit          = (open_count_ff != '0);
         open_key_in   = '0;
         open_count_in = '0;
      end else if (is_low) begin
         // Drop the out-of-order record, keep the open group.
         emit               = 1'b1;
         result.kind        = KIND_ERROR;
         result.group_key   = q_rdata.key;
         result.group_count = '0;
      end else if (split) begin
         emit          = (open_count_ff != '0);
         open_key_in   = q_rdata.key;
         open_count_in = q_rdata.count;
      end else begin
         open_count_in = sum[CNT_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (q_pop && emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_key_ff   <= '0;
         open_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            open_key_ff   <= open_key_in;
            open_count_ff <= open_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.kind == KIND_ERROR |-> rsp_payload_ff.group_count == '0)
      else $error("error result with nonzero count");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.kind == KIND_GROUP |-> rsp_payload_ff.group_count != '0)
      else $error("empty group emitted");
   assert property (@(posedge clock) disable iff (reset)
      q_pop && q_rdata.is_end |=> open_count_ff == '0 && open_key_ff == '0)
      else $error("open group not cleared after end");
   assert property (@(posedge clock) disable iff (reset)
      q_pop && !q_rdata.is_end && is_low |=> $stable(open_key_ff) && $stable(open_count_ff))
      else $error("dropped record changed the open group");

endmodule
`default_nettype wire

@@ rtl/sorted_key_count_aggregator.sv @@
// Path: a request accepted into the front register is written to the queue and then
//   loaded into the result register, which drives rsp_valid; a full queue or a stalled
//   result can hold it in between. The open-group compare and add are combinational.
// Throughput: one request per cycle while neither the queue nor the result stalls.
// A four-entry queue between front and back absorbs short stalls on either side.
// Reset (synchronous): zoom 0, count cap all ones, open group empty, queue and
//   result register empty.
`default_nettype none
module sorted_key_count_aggregator
   import ska_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_payload_type   req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   cfg_type       cfg;
   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          q_not_empty;
   que_entry_type q_wdata;
   que_entry_type q_rdata;

   ska_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ska_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .zoom        (cfg.zoom),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   ska_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   ska_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (q_not_empty),
      .q_rdata     (q_rdata),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ bench/group_sum_checker.sv @@
module group_sum_checker
   import ska_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_payload_type   req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_payload_type   rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   input  logic [DATA_W-1:0] prdata,
   input  logic              pready,
   output int                mismatches,
   output int                outstanding
);

   logic [ZOOM_W-1:0] zoom_copy;
   logic [CNT_W-1:0]  limit_copy;
   logic [KEY_W-1:0]  run_key;
   logic [CNT_W-1:0]  run_total;
   rsp_payload_type   pending_groups[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic logic [KEY_W-1:0] level_mask(input logic [ZOOM_W-1:0] z);
      int kept;
      kept = (z > ZOOM_W'(ZOOM_FULL)) ? 2 * ZOOM_FULL : 2 * int'(z);
      if (kept == 0)
         return '0;
      if (kept >= KEY_W)
         return '1;
      return ~({KEY_W{1'b1}} >> kept);
   endfunction

   function automatic rsp_payload_type make_result(input logic kind,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [CNT_W-1:0] c);
      rsp_payload_type r;
      r.kind        = kind;
      r.group_key   = k;
      r.group_count = c;
      return r;
   endfunction

   // append at the tail so results are checked in order
   function automatic void add_expected(input rsp_payload_type r);
      pending_groups.insert(pending_groups.size(), r);
   endfunction

   task automatic fold_request(input req_payload_type r);
      logic [KEY_W-1:0] k;
      logic [CNT_W:0]   sum;
      if (r.cmd == CMD_END) begin
         if (run_total != 0)
            add_expected(make_result(KIND_GROUP, run_key, run_total));
         run_key   = '0;
         run_total = '0;
      end else begin
         k = r.key & level_mask(zoom_copy);
         if (k < run_key) begin
            // drop the request, state untouched
            add_expected(make_result(KIND_ERROR, k, '0));
         end else begin
            sum = {1'b0, run_total} + {1'b0, r.count};
            if (k != run_key || sum > {1'b0, limit_copy}) begin
               if (run_total != 0)
                  add_expected(make_result(KIND_GROUP, run_key, run_total));
               run_key   = k;
               run_total = r.count;
            end else begin
               run_total = sum[CNT_W-1:0];
            end
         end
      end
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_groups.size() == 0) begin
         $error("unexpected result: kind %0d group_key %h group_count %h",
                got.kind, got.group_key, got.group_count);
         mismatches++;
      end else begin
         want = pending_groups.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
         end
         if (got.group_key !== want.group_key) begin
            $error("group_key: expected %h, got %h", want.group_key, got.group_key);
            mismatches++;
         end
         if (got.group_count !== want.group_count) begin
            $error("group_count: expected %h, got %h", want.group_count, got.group_count);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      logic [DATA_W-1:0] shadow;
      if (reset) begin
         zoom_copy  = '0;
         limit_copy = '1;
         run_key    = '0;
         run_total  = '0;
         pending_groups.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[ADDR_W-1:2] == REG_ZOOM)
                  zoom_copy = pwdata[ZOOM_W-1:0];
               else
                  limit_copy = pwdata[CNT_W-1:0];
            end else begin
               shadow = (paddr[ADDR_W-1:2] == REG_ZOOM) ? DATA_W'(zoom_copy)
                                                         : DATA_W'(limit_copy);
               if (prdata !== shadow) begin
                  $error("prdata: expected %h, got %h", shadow, prdata);
                  mismatches++;
               end
            end
         end
         // compare before predicting so a fresh request cannot hide a stray result
         if (rsp_valid && !rsp_stall)
            check_result(rsp_payload);
         if (req_valid && !req_stall)
            fold_request(req_payload);
      end
      outstanding <= pending_groups.size();
   end

endmodule

@@ bench/sorted_key_count_aggregator_tb.sv @@
module sorted_key_count_aggregator_tb;
   import ska_pkg::*;

   localparam logic [ADDR_W-1:0] ZOOM_ADDR  = {REG_ZOOM, 2'b00};
   localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_COUNT_CAP, 2'b00};
   localparam int PHASES          = 9;
   localparam int PHASE_REQUESTS  = 110;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_style_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_payload_type   req_payload;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_payload_type   rsp_payload;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                mismatches;
   int                outstanding;

   logic [KEY_W-1:0]  key_cursor;
   logic [ZOOM_W-1:0] zoom_now;
   logic [CNT_W-1:0]  max_now;
   int                burst_left;
   bit                calm;

   stall_style_type   stall_style = STALL_NONE;
   int                stall_left  = 0;
   int                stall_tick  = 0;

   logic [ZOOM_W-1:0] zoom_plan [PHASES] = '{6'd1, 6'd32, 6'd16, 6'd40, 6'd0, 6'd8,
                                              6'd31, 6'd63, 6'd24};
   logic [CNT_W-1:0]  limit_plan[PHASES] = '{32'hFFFF_FFFF, 32'd1, 32'd1000, 32'hFFFF_FFFF,
                                              32'd50, 32'd0, 32'd0, 32'h8000_0000, 32'd7};

   sorted_key_count_aggregator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   group_sum_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   always #6 clock = ~clock;

   // receiver backpressure: switch to a randomly chosen style when the current one runs out
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_left  <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
         default:     rsp_stall <= ((stall_tick % 5) < 2);
      endcase
   end

   function automatic req_payload_type make_request(input logic cmd,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [CNT_W-1:0] c);
      req_payload_type r;
      r.cmd   = cmd;
      r.key   = k;
      r.count = c;
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2, 3: return CNT_W'($urandom_range(1, 9));
         4:       return max_now >> $urandom_range(1, 4);
         5:       return max_now;
         6:       return max_now + 1'b1;
         7:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input req_payload_type p);
      int gap;
      if (burst_left == 0) begin
         gap        = calm ? 0 : $urandom_range(0, 6);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_payload = p;
      req_valid   = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_requests();
      req_valid  = 1'b0;
      burst_left = 0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = a;
      pwdata  = d;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_config(input logic [ZOOM_W-1:0] z, input logic [CNT_W-1:0] m);
      hold_requests();
      // let requests that produce no result leave the pipeline
      repeat (20) @(negedge clock);
      csr_access(1'b1, ZOOM_ADDR, DATA_W'(z));
      csr_access(1'b0, ZOOM_ADDR, '0);
      csr_access(1'b1, LIMIT_ADDR, DATA_W'(m));
      csr_access(1'b0, LIMIT_ADDR, '0);
      zoom_now = z;
      max_now  = m;
   endtask

   task automatic random_request(output req_payload_type r);
      logic [KEY_W-1:0] wide;
      logic [KEY_W-1:0] step;
      logic [KEY_W-1:0] next_key;
      int               pick;
      int               sh;
      wide = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r          = make_request(CMD_END, wide, $urandom);
         key_cursor = {$urandom, $urandom} >> $urandom_range(8, 63);
      end else if (pick < 16 && key_cursor != 0) begin
         r = make_request(CMD_RECORD, wide % key_cursor, pick_count());
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: step = '0;
            4, 5:       step = KEY_W'($urandom_range(1, 255));
            6, 7:       step = wide >> $urandom_range(0, 63);
            default: begin
               // step across the mask boundary of the current zoom
               sh   = KEY_W - 2 * ((zoom_now > ZOOM_W'(ZOOM_FULL)) ? ZOOM_FULL : int'(zoom_now))
                      + $urandom_range(0, 2);
               step = (sh < KEY_W) ? (KEY_W'(1) << sh) : KEY_W'($urandom_range(1, 255));
            end
         endcase
         next_key   = key_cursor + step;
         key_cursor = (next_key < key_cursor) ? '1 : next_key;
         r          = make_request(CMD_RECORD, key_cursor, pick_count());
      end
   endtask

   initial begin
      req_payload_type r;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      key_cursor  = '0;
      zoom_now    = '0;
      max_now     = '1;
      burst_left  = 0;
      calm        = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: every key masks to zero
      send(make_request(CMD_RECORD, '1, '0));
      send(make_request(CMD_RECORD, 64'h5A5A_0F0F_3C3C_9696, '1));
      send(make_request(CMD_RECORD, 64'h0000_0000_0000_0001, 32'd1));
      send(make_request(CMD_END, '0, '0));
      send(make_request(CMD_END, '1, '1));

      // zoom above full range keeps the whole key
      set_config(6'd63, 32'd1000);
      send(make_request(CMD_RECORD, '1, 32'd5));
      send(make_request(CMD_RECORD, '0, 32'd3));
      send(make_request(CMD_RECORD, '1, 32'd5000));
      send(make_request(CMD_RECORD, '1, 32'd1));
      send(make_request(CMD_END, '0, '0));
      send(make_request(CMD_RECORD, 64'h0123_4567_89AB_CDEF, '0));
      send(make_request(CMD_RECORD, 64'h0124_0000_0000_0000, '0));
      send(make_request(CMD_END, '0, '0));
      send(make_request(CMD_RECORD, 64'h8000_0000_0000_0000, 32'd1000));
      send(make_request(CMD_RECORD, 64'h8000_0000_0000_0000, '0));
      send(make_request(CMD_RECORD, 64'h8000_0000_0000_0000, 32'd1));
      send(make_request(CMD_END, 64'hFFFF_0000_FFFF_0000, 32'hDEAD_BEEF));

      // coarsest mask: only the top two bits survive
      set_config(6'd1, '1);
      send(make_request(CMD_RECORD, 64'h4000_0000_0000_0000, 32'd7));
      send(make_request(CMD_RECORD, 64'h7FFF_FFFF_FFFF_FFFF, 32'd9));
      send(make_request(CMD_RECORD, 64'h3FFF_FFFF_FFFF_FFFF, 32'd2));
      send(make_request(CMD_RECORD, 64'hC000_0000_0000_0001, '1));
      send(make_request(CMD_END, '0, '0));

      for (int ph = 0; ph < PHASES; ph++) begin
         set_config(zoom_plan[ph], (limit_plan[ph] == 0) ? ($urandom | 32'd1) : limit_plan[ph]);
         calm       = ($urandom_range(0, 3) == 0);
         key_cursor = {$urandom, $urandom} >> $urandom_range(4, 63);
         send(make_request(CMD_END, '0, '0));
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            if (i == PHASE_REQUESTS / 2)
               hold_requests();
            random_request(r);
            send(r);
         end
      end

      hold_requests();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ska_pkg.sv
rtl/ska_csr.sv
rtl/ska_front.sv
rtl/ska_fifo.sv
rtl/ska_back.sv
rtl/sorted_key_count_aggregator.sv
bench/group_sum_checker.sv
bench/sorted_key_count_aggregator_tb.sv
